FILE: hdl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared widths, codes and types of the waypoint follower.
// ----------------------------------------------------------------------------
package wpf_pkg;

    // block sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int COORD_WIDTH  = 24;

    // fixed field widths
    localparam int SPEED_WIDTH  = 16;
    localparam int LEFT_WIDTH   = 5;
    localparam int CMD_WIDTH    = 2;
    localparam int STATUS_WIDTH = 2;

    // derived widths
    localparam int QIDX_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_WIDTH   = QIDX_WIDTH + 1;
    localparam int MAG_WIDTH    = COORD_WIDTH + 1;
    localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
    localparam int ROOT_WIDTH   = MAG_WIDTH;
    localparam int PROD_WIDTH   = MAG_WIDTH + SPEED_WIDTH;
    localparam int LCNT_WIDTH   = $clog2(MAG_WIDTH);
    localparam int SCNT_WIDTH   = $clog2(SPEED_WIDTH);

    localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = SPEED_WIDTH'(256);

    // command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_PUSH = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_SET  = 2'd2;

    // status codes
    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

    // one queued waypoint
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_point;

    // sequencer controls for a scaling unit
    typedef struct packed {
        logic mul_start;
        logic div_start;
    } t_scale_ctl;

endpackage

FILE: hdl/wpf_length.sv
// ----------------------------------------------------------------------------
// wpf_length
// Vector length: serial sum of squares, then a bit-per-cycle integer root.
// ----------------------------------------------------------------------------
module wpf_length (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [wpf_pkg::MAG_WIDTH-1:0]       i_mag_x,
    input  logic [wpf_pkg::MAG_WIDTH-1:0]       i_mag_y,
    output logic                                o_done,
    output logic [wpf_pkg::ROOT_WIDTH-1:0]      o_len
);

    localparam int DW = wpf_pkg::MAG_WIDTH;
    localparam int SW = wpf_pkg::SQ_WIDTH;
    localparam int RW = wpf_pkg::ROOT_WIDTH;
    localparam int CW = wpf_pkg::LCNT_WIDTH;

    typedef enum logic [2:0] {
        LS_IDLE = 3'b001,
        LS_SQ   = 3'b010,
        LS_RT   = 3'b100
    } t_len_state;

    t_len_state    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_mx, n_mx, r_my, n_my;
    logic [DW-1:0] r_bx, n_bx, r_by, n_by;
    logic [SW-1:0] r_acc, n_acc;
    logic [RW+1:0] r_rem, n_rem;
    logic [RW-1:0] r_root, n_root;
    logic          r_done, n_done;

    logic [RW+3:0] w_cur, w_trial, w_diff;

    // one root step: bring down two radicand bits and try the next root bit
    assign w_cur   = {r_rem, r_acc[SW-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_diff  = w_cur - w_trial;

    // sequencer and datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mx    = r_mx;
        n_my    = r_my;
        n_bx    = r_bx;
        n_by    = r_by;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_root  = r_root;
        n_done  = 1'b0;
        unique case (r_state)
            LS_IDLE: begin
                if (i_start) begin
                    n_mx    = i_mag_x;
                    n_my    = i_mag_y;
                    n_bx    = i_mag_x;
                    n_by    = i_mag_y;
                    n_acc   = '0;
                    n_cnt   = CW'(DW - 1);
                    n_state = LS_SQ;
                end
            end
            LS_SQ: begin
                // msb-first shift-add of both squares into one sum
                n_acc = (r_acc << 1)
                      + (r_bx[DW-1] ? SW'(r_mx) : '0)
                      + (r_by[DW-1] ? SW'(r_my) : '0);
                n_bx  = r_bx << 1;
                n_by  = r_by << 1;
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CW'(RW - 1);
                    n_state = LS_RT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            LS_RT: begin
                if (w_cur >= w_trial) begin
                    n_rem  = w_diff[RW+1:0];
                    n_root = {r_root[RW-2:0], 1'b1};
                end else begin
                    n_rem  = w_cur[RW+1:0];
                    n_root = {r_root[RW-2:0], 1'b0};
                end
                n_acc = r_acc << 2;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = LS_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_len  = r_root;

endmodule

FILE: hdl/wpf_scale.sv
// ----------------------------------------------------------------------------
// wpf_scale
// Per-axis step: serial magnitude times speed, then restoring divide by length.
// ----------------------------------------------------------------------------
module wpf_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wpf_pkg::t_scale_ctl                 i_ctl,
    input  logic [wpf_pkg::MAG_WIDTH-1:0]       i_mag,
    input  logic [wpf_pkg::SPEED_WIDTH-1:0]     i_speed,
    input  logic [wpf_pkg::ROOT_WIDTH-1:0]      i_len,
    output logic                                o_done,
    output logic [wpf_pkg::SPEED_WIDTH-1:0]     o_quot
);

    localparam int DW = wpf_pkg::MAG_WIDTH;
    localparam int QW = wpf_pkg::SPEED_WIDTH;
    localparam int RW = wpf_pkg::ROOT_WIDTH;
    localparam int PW = wpf_pkg::PROD_WIDTH;
    localparam int CW = wpf_pkg::SCNT_WIDTH;

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_MUL  = 3'b010,
        SC_DIV  = 3'b100
    } t_scale_state;

    t_scale_state  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_mag, n_mag;
    logic [QW-1:0] r_sp, n_sp;
    logic [PW-1:0] r_prod, n_prod;
    logic [RW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quot, n_quot;
    logic          r_done, n_done;

    logic [RW:0]   w_try, w_sub;

    // divide step: shift in the next dividend bit and compare with the length
    assign w_try = {r_rem, r_quot[QW-1]};
    assign w_sub = w_try - {1'b0, i_len};

    // sequencer and datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_sp    = r_sp;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_done  = 1'b0;
        unique case (r_state)
            SC_IDLE: begin
                if (i_ctl.mul_start) begin
                    n_mag   = i_mag;
                    n_sp    = i_speed;
                    n_prod  = '0;
                    n_cnt   = CW'(QW - 1);
                    n_state = SC_MUL;
                end else if (i_ctl.div_start) begin
                    // magnitude never exceeds the length, so the upper part is below it
                    n_rem   = RW'(r_prod >> QW);
                    n_quot  = r_prod[QW-1:0];
                    n_cnt   = CW'(QW - 1);
                    n_state = SC_DIV;
                end
            end
            SC_MUL: begin
                n_prod = (r_prod << 1) + (r_sp[QW-1] ? PW'(r_mag) : '0);
                n_sp   = r_sp << 1;
                if (r_cnt == '0) begin
                    n_state = SC_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            SC_DIV: begin
                if (w_try >= {1'b0, i_len}) begin
                    n_rem  = w_sub[RW-1:0];
                    n_quot = {r_quot[QW-2:0], 1'b1};
                end else begin
                    n_rem  = w_try[RW-1:0];
                    n_quot = {r_quot[QW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = SC_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_sp   <= n_sp;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/waypoint_follower_step.sv
// ----------------------------------------------------------------------------
// waypoint_follower_step
// Moves a point at constant speed along a queue of waypoints.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one command beat: tick,
// push waypoint or set position, with the coordinates for the last two.
// Every command beat produces exactly one result beat on the output channel
// (o_out_valid / i_out_ready): position, queue fill, reached flag, status.
// The config channel (i_cfg_valid / o_cfg_ready) writes move_speed and is
// always ready; write it only while no command is in flight.
// Push, set, unused command and a tick on an empty queue go straight to the
// finish state, which loads the output register. A tick on a non-empty queue
// runs the 25-step sum of squares and the 25-step root in the length unit;
// when it moves instead of snapping to the waypoint, it then adds the
// 16-step divide in the two per-axis scaling units.
// One command is in flight at a time; a new input beat is taken while the
// previous result still sits in the output register.
// If the receiver stalls, the finished result waits until the output
// register frees and input stays blocked meanwhile.
// Reset puts the point at the origin, empties the queue, sets speed to
// 256 and drops any pending result. Queue storage is not cleared.
// ----------------------------------------------------------------------------
module waypoint_follower_step (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // command channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [wpf_pkg::CMD_WIDTH-1:0]           i_command,
    input  logic signed [wpf_pkg::COORD_WIDTH-1:0]  i_coord_x,
    input  logic signed [wpf_pkg::COORD_WIDTH-1:0]  i_coord_y,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [wpf_pkg::COORD_WIDTH-1:0]  o_pos_x,
    output logic signed [wpf_pkg::COORD_WIDTH-1:0]  o_pos_y,
    output logic [wpf_pkg::LEFT_WIDTH-1:0]          o_waypoints_left,
    output logic                                    o_reached,
    output logic [wpf_pkg::STATUS_WIDTH-1:0]        o_status,
    // config channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [wpf_pkg::SPEED_WIDTH-1:0]         i_cfg_move_speed
);

    localparam int XW = wpf_pkg::COORD_WIDTH;
    localparam int DW = wpf_pkg::MAG_WIDTH;
    localparam int RW = wpf_pkg::ROOT_WIDTH;
    localparam int QW = wpf_pkg::SPEED_WIDTH;
    localparam int IW = wpf_pkg::QIDX_WIDTH;
    localparam int NW = wpf_pkg::QCNT_WIDTH;
    localparam int AW = wpf_pkg::QSUM_WIDTH;
    localparam int LW = wpf_pkg::LEFT_WIDTH;
    localparam int TW = wpf_pkg::STATUS_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LEN  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // waypoint queue storage
    wpf_pkg::t_point r_queue [wpf_pkg::QUEUE_DEPTH];
    wpf_pkg::t_point r_rd;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_head, n_head;
    logic [NW-1:0]          r_count, n_count;
    logic signed [XW-1:0]   r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [QW-1:0]          r_speed, n_speed;
    logic                   r_neg_x, n_neg_x, r_neg_y, n_neg_y;
    logic                   r_reached, n_reached;
    logic [TW-1:0]          r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    logic signed [XW-1:0]   r_out_x, n_out_x, r_out_y, n_out_y;
    logic [LW-1:0]          r_out_left, n_out_left;
    logic                   r_out_reached, n_out_reached;
    logic [TW-1:0]          r_out_status, n_out_status;

    logic                   w_accept;
    logic                   w_wr_en, w_rd_en;
    logic [AW-1:0]          w_sum, w_slot_sum, w_head_inc;
    logic [IW-1:0]          w_slot, w_head_next;
    logic signed [XW:0]     w_dx, w_dy;
    logic [DW-1:0]          w_mag_x, w_mag_y;
    logic                   w_len_done;
    logic [RW-1:0]          w_len;
    logic                   w_snap;
    wpf_pkg::t_scale_ctl    w_ctl;
    logic                   w_qx_done, w_qy_done;
    logic [QW-1:0]          w_qx, w_qy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // tail slot and next head, wrapped into the queue depth
    assign w_sum       = AW'(r_head) + AW'(r_count);
    assign w_slot_sum  = (w_sum >= AW'(wpf_pkg::QUEUE_DEPTH))
                       ? w_sum - AW'(wpf_pkg::QUEUE_DEPTH) : w_sum;
    assign w_slot      = w_slot_sum[IW-1:0];
    assign w_head_inc  = AW'(r_head) + 1'b1;
    assign w_head_next = (w_head_inc >= AW'(wpf_pkg::QUEUE_DEPTH))
                       ? '0 : w_head_inc[IW-1:0];

    // heading to the front waypoint
    assign w_dx    = {r_rd.x[XW-1], r_rd.x} - {r_pos_x[XW-1], r_pos_x};
    assign w_dy    = {r_rd.y[XW-1], r_rd.y} - {r_pos_y[XW-1], r_pos_y};
    assign w_mag_x = w_dx[XW] ? DW'(-w_dx) : DW'(w_dx);
    assign w_mag_y = w_dy[XW] ? DW'(-w_dy) : DW'(w_dy);

    assign w_snap = ((RW + QW)'(r_speed) >= (RW + QW)'(w_len));

    // start both products with the length, divide once the length is known and the point does not snap
    assign w_ctl.mul_start = (r_state == S_READ);
    assign w_ctl.div_start = (r_state == S_LEN) && w_len_done && !w_snap;

    wpf_length u_length (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_READ),
        .i_mag_x (w_mag_x),
        .i_mag_y (w_mag_y),
        .o_done  (w_len_done),
        .o_len   (w_len)
    );

    wpf_scale u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag_x),
        .i_speed (r_speed),
        .i_len   (w_len),
        .o_done  (w_qx_done),
        .o_quot  (w_qx)
    );

    wpf_scale u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mag   (w_mag_y),
        .i_speed (r_speed),
        .i_len   (w_len),
        .o_done  (w_qy_done),
        .o_quot  (w_qy)
    );

    // command sequencer
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_speed       = r_speed;
        n_neg_x       = r_neg_x;
        n_neg_y       = r_neg_y;
        n_reached     = r_reached;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        n_out_x       = r_out_x;
        n_out_y       = r_out_y;
        n_out_left    = r_out_left;
        n_out_reached = r_out_reached;
        n_out_status  = r_out_status;
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;

        if (i_cfg_valid) begin
            n_speed = i_cfg_move_speed;
        end

        // result beat taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_reached = 1'b0;
                    n_status  = wpf_pkg::ST_OK;
                    n_state   = S_FIN;
                    unique case (i_command)
                        wpf_pkg::CMD_TICK: begin
                            if (r_count == '0) begin
                                n_status = wpf_pkg::ST_EMPTY;
                            end else begin
                                w_rd_en = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        wpf_pkg::CMD_PUSH: begin
                            if (r_count == NW'(wpf_pkg::QUEUE_DEPTH)) begin
                                n_status = wpf_pkg::ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        wpf_pkg::CMD_SET: begin
                            n_pos_x = i_coord_x;
                            n_pos_y = i_coord_y;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_neg_x = w_dx[XW];
                n_neg_y = w_dy[XW];
                n_state = S_LEN;
            end
            S_LEN: begin
                if (w_len_done) begin
                    if (w_snap) begin
                        n_pos_x   = r_rd.x;
                        n_pos_y   = r_rd.y;
                        n_head    = w_head_next;
                        n_count   = r_count - 1'b1;
                        n_reached = 1'b1;
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // step wraps into the coordinate width
                if (w_qx_done) begin
                    n_pos_x = r_neg_x ? r_pos_x - XW'(w_qx) : r_pos_x + XW'(w_qx);
                    n_pos_y = r_neg_y ? r_pos_y - XW'(w_qy) : r_pos_y + XW'(w_qy);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_x       = r_pos_x;
                    n_out_y       = r_pos_y;
                    n_out_left    = LW'(r_count);
                    n_out_reached = r_reached;
                    n_out_status  = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // queue memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_queue[w_slot] <= '{x: i_coord_x, y: i_coord_y};
        end
        if (w_rd_en) begin
            r_rd <= r_queue[r_head];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_speed     <= wpf_pkg::SPEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_speed     <= n_speed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_neg_x       <= n_neg_x;
        r_neg_y       <= n_neg_y;
        r_reached     <= n_reached;
        r_status      <= n_status;
        r_out_x       <= n_out_x;
        r_out_y       <= n_out_y;
        r_out_left    <= n_out_left;
        r_out_reached <= n_out_reached;
        r_out_status  <= n_out_status;
    end

    assign o_out_valid      = r_out_valid;
    assign o_pos_x          = r_out_x;
    assign o_pos_y          = r_out_y;
    assign o_waypoints_left = r_out_left;
    assign o_reached        = r_out_reached;
    assign o_status         = r_out_status;

    // queue fill never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(wpf_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // a snap result always reports ok
    a_reached_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reached |-> o_status == wpf_pkg::ST_OK)
        else $error("reached with non-ok status");

    // an empty tick reports an empty queue
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == wpf_pkg::ST_EMPTY) |-> o_waypoints_left == '0)
        else $error("empty status with queued waypoints");

    // a partial step never exceeds the speed on either axis
    a_quot_below_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qx_done |-> (w_qx <= r_speed) && (w_qy <= r_speed) && w_qy_done)
        else $error("step quotient above speed");

    // the length unit only finishes while the sequencer waits for it
    a_len_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len_done |-> r_state == S_LEN)
        else $error("length done outside length wait");

endmodule
